FILE: design/kwal_pkg.sv
// Package for the keyword-aware lexer: scan modes, token kinds, token record,
// keyword table and character class helpers.
// No dependencies.
`timescale 1ns / 1ps

package kwal_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int NUM_KW          = 5;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [15:0] LEN_MAX        = 16'hFFFF;
    localparam logic [4:0]  ALL_CANDIDATES = 5'h1F;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_STR  = 3'd3,
        MODE_EQ   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_STRING  = 3'd3,
        KIND_OPER    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  kw_index;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // if, else, while, int, return; padded with zeros to eight positions
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd6};

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == LEN_MAX) ? LEN_MAX : v + 16'd1;
    endfunction

    // keep the candidates whose character at pos equals c
    function automatic logic [4:0] filter_candidates(input logic [4:0]  live,
                                                     input logic [15:0] pos,
                                                     input logic [7:0]  c);
        logic [4:0] keep;
        keep = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (live[k] && (pos < 16'(KW_LEN[k])) && (KW_TEXT[k][pos[2:0]] == c)) begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

    // index of the first live keyword of the given length; bit 3 flags a hit
    function automatic logic [3:0] keyword_match(input logic [4:0]  live,
                                                 input logic [15:0] len);
        logic [3:0] hit;
        hit = '0;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (live[k] && (16'(KW_LEN[k]) == len)) begin
                hit = {1'b1, 3'(k)};
            end
        end
        return hit;
    endfunction

endpackage

FILE: design/kwal_scan.sv
// Scanner core of the keyword-aware lexer: pending-token state and the
// per-character step that yields up to two tokens. Depends on kwal_pkg.
`timescale 1ns / 1ps

module kwal_scan #(
    parameter int OFFSET_BITS = kwal_pkg::OFFSET_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            cmd_end,
    input  logic [7:0]      char_code,
    output kwal_pkg::token_t res0,
    output kwal_pkg::token_t res1,
    output logic [1:0]      res_count
);
    import kwal_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic                   quote_single_reg, quote_single_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;
    logic [15:0]            plen_reg, plen_next;
    logic [4:0]             cand_reg, cand_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic                   flush;
    logic                   op_hit;
    logic                   done;
    logic [15:0]            flush_len;
    logic [3:0]             kw_hit;
    logic [OFFSET_BITS+15:0] pstart_ext;
    logic [OFFSET_BITS+15:0] offset_ext;
    token_t                 flush_tok;
    token_t                 op_tok;

    always_comb begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        pstart_next       = pstart_reg;
        plen_next         = plen_reg;
        cand_next         = cand_reg;
        offset_next       = offset_reg;
        flush             = 1'b0;
        op_hit            = 1'b0;
        done              = 1'b0;
        flush_len         = plen_reg;

        if (cmd_end) begin
            flush             = (mode_reg != MODE_IDLE);
            mode_next         = MODE_IDLE;
            quote_single_next = 1'b0;
            pstart_next       = '0;
            plen_next         = '0;
            cand_next         = ALL_CANDIDATES;
            offset_next       = '0;
        end else begin
            case (mode_reg)
                MODE_STR: begin
                    plen_next = sat_inc(plen_reg);
                    flush_len = plen_next;
                    done      = 1'b1;
                    if (char_code == (quote_single_reg ? 8'h27 : 8'h22)) begin
                        flush     = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (is_letter(char_code) || is_digit(char_code) || char_code == "_") begin
                        cand_next = filter_candidates(cand_reg, plen_reg, char_code);
                        plen_next = sat_inc(plen_reg);
                        done      = 1'b1;
                    end else begin
                        flush     = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(char_code)) begin
                        plen_next = sat_inc(plen_reg);
                        done      = 1'b1;
                    end else begin
                        flush     = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_EQ: begin
                    flush     = 1'b1;
                    mode_next = MODE_IDLE;
                    if (char_code == "=") begin
                        flush_len = 16'd2;
                        plen_next = 16'd2;
                        done      = 1'b1;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (!done && !is_space(char_code)) begin
                if (is_letter(char_code) || char_code == "_") begin
                    mode_next   = MODE_WORD;
                    pstart_next = offset_reg;
                    plen_next   = 16'd1;
                    cand_next   = filter_candidates(ALL_CANDIDATES, 16'd0, char_code);
                end else if (is_digit(char_code)) begin
                    mode_next   = MODE_NUM;
                    pstart_next = offset_reg;
                    plen_next   = 16'd1;
                end else if (char_code == 8'h22 || char_code == 8'h27) begin
                    mode_next         = MODE_STR;
                    quote_single_next = (char_code == 8'h27);
                    pstart_next       = offset_reg;
                    plen_next         = 16'd1;
                end else if (char_code == "=") begin
                    mode_next   = MODE_EQ;
                    pstart_next = offset_reg;
                    plen_next   = 16'd1;
                end else if (char_code inside {"+", "-", "*", "/"}) begin
                    op_hit = 1'b1;
                end
            end
            offset_next = offset_reg + OFFSET_BITS'(1);
        end
    end

    assign pstart_ext = {16'h0000, pstart_reg};
    assign offset_ext = {16'h0000, offset_reg};
    assign kw_hit     = keyword_match(cand_reg, plen_reg);

    always_comb begin
        flush_tok.kw_index = 3'd0;
        flush_tok.start    = pstart_ext[15:0];
        flush_tok.length   = flush_len;
        flush_tok.last     = !op_hit;
        case (mode_reg)
            MODE_WORD: begin
                if (kw_hit[3]) begin
                    flush_tok.kind     = KIND_KEYWORD;
                    flush_tok.kw_index = kw_hit[2:0];
                end else begin
                    flush_tok.kind = KIND_IDENT;
                end
            end
            MODE_NUM: flush_tok.kind = KIND_NUMBER;
            MODE_STR: flush_tok.kind = KIND_STRING;
            default:  flush_tok.kind = KIND_OPER;
        endcase

        op_tok.kind     = KIND_OPER;
        op_tok.kw_index = 3'd0;
        op_tok.start    = offset_ext[15:0];
        op_tok.length   = 16'd1;
        op_tok.last     = 1'b1;
    end

    assign res0      = flush ? flush_tok : op_tok;
    assign res1      = op_tok;
    assign res_count = advance ? (2'(flush) + 2'(op_hit)) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            pstart_reg       <= '0;
            plen_reg         <= '0;
            cand_reg         <= ALL_CANDIDATES;
            offset_reg       <= '0;
        end else if (advance) begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            pstart_reg       <= pstart_next;
            plen_reg         <= plen_next;
            cand_reg         <= cand_next;
            offset_reg       <= offset_next;
        end
    end

endmodule

FILE: design/kwal_result_queue.sv
// Result queue of the keyword-aware lexer: takes up to two tokens a cycle
// and hands out one a cycle while out_ready is high. Depends on kwal_pkg.
`timescale 1ns / 1ps

module kwal_result_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  kwal_pkg::token_t push0,
    input  kwal_pkg::token_t push1,
    input  logic [1:0]       push_count,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output kwal_pkg::token_t out_tok
);
    import kwal_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    token_t              mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] head_reg, head_next;
    logic [PTR_BITS-1:0] tail_reg, tail_next;
    logic [PTR_BITS:0]   count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[head_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= (PTR_BITS + 1)'(QUEUE_DEPTH - 2));

    always_comb begin
        head_next  = head_reg + PTR_BITS'(pop);
        tail_next  = tail_reg + PTR_BITS'(push_count);
        count_next = count_reg + (PTR_BITS + 1)'(push_count) - (PTR_BITS + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[tail_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[tail_reg + PTR_BITS'(1)] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/keyword_aware_lexer.sv
// Keyword-aware lexer: takes one source character per transaction and
// returns tokens as kind, keyword index, start offset and length. An input
// transaction is taken every cycle while the four-entry result queue has
// room for two tokens; each character is classified in the same cycle it
// is taken, and its tokens are registered into the result queue. A character
// may yield two tokens, so a sustained stream is limited by the one token
// per cycle drained on the result side while m_tready is high. Depends on
// kwal_pkg, kwal_scan and kwal_result_queue.
`timescale 1ns / 1ps

module keyword_aware_lexer #(
    parameter int OFFSET_BITS = kwal_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] cmd (1 = end of source)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] keyword_index, [18:3] token_start,
                                   // [34:19] token_length, [39:35] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_result
);
    import kwal_pkg::*;

    logic       advance;
    logic       room;
    logic [1:0] res_count;
    token_t     res0;
    token_t     res1;
    token_t     out_tok;

    assign s_tready = room;
    assign advance  = s_tvalid && room;

    kwal_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cmd_end   (s_tuser),
        .char_code (s_tdata),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    kwal_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (res0),
        .push1      (res1),
        .push_count (res_count),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tok    (out_tok)
    );

    assign m_tdata = {5'b00000, out_tok.length, out_tok.start, out_tok.kw_index};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.last;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for keyword_aware_lexer: a directed table, a long
// string and a long word, then random token streams.
// Depends on kwal_pkg and keyword_aware_lexer; expected tokens come from a local lexer model.
`timescale 1ns / 1ps

module tb_top;
    import kwal_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int LONG_RUN       = 48;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic        cmd;
        logic [7:0]  ch;
        bit          typed;
        token_t      tok;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    keyword_aware_lexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    string kw_words [NUM_KW] = '{"if", "else", "while", "int", "return"};
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    mode_t       lx_mode;
    logic        lx_single;
    logic [15:0] lx_start;
    logic [15:0] lx_len;
    logic [4:0]  lx_cands;
    logic [15:0] lx_offset;

    token_t      want_tokens [$];
    token_t      step_tokens [$];
    int          step_count;
    stim_row_t   stim_table [$];
    int          err_count   = 0;
    int          sent_items  = 0;
    int          idle_cycles = 0;
    bit          feed_burst  = 1'b0;
    bit          drain_burst = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic bit ch_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit ch_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit ch_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == LEN_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [4:0] narrow_cands(input logic [4:0] live, input logic [15:0] pos,
                                                input logic [7:0] c);
        logic [4:0] keep;
        keep = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (live[k] && pos < kw_words[k].len() && kw_words[k][pos] == c) begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

    function automatic token_t make_tok(input kind_t kind, input logic [2:0] idx,
                                        input logic [15:0] st, input logic [15:0] ln);
        token_t t;
        t.kind     = kind;
        t.kw_index = idx;
        t.start    = st;
        t.length   = ln;
        t.last     = 1'b0;
        return t;
    endfunction

    function automatic void add_step_tok(input token_t t);
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void clear_lexer();
        lx_mode   = MODE_IDLE;
        lx_single = 1'b0;
        lx_start  = '0;
        lx_len    = '0;
        lx_cands  = ALL_CANDIDATES;
        lx_offset = '0;
    endfunction

    function automatic void close_token();
        int hit;
        hit = -1;
        case (lx_mode)
            MODE_WORD: begin
                for (int k = 0; k < NUM_KW; k++) begin
                    if (hit < 0 && lx_cands[k] && kw_words[k].len() == lx_len) hit = k;
                end
                if (hit >= 0) begin
                    add_step_tok(make_tok(KIND_KEYWORD, 3'(hit), lx_start, lx_len));
                end else begin
                    add_step_tok(make_tok(KIND_IDENT, 3'd0, lx_start, lx_len));
                end
            end
            MODE_NUM: add_step_tok(make_tok(KIND_NUMBER, 3'd0, lx_start, lx_len));
            MODE_STR: add_step_tok(make_tok(KIND_STRING, 3'd0, lx_start, lx_len));
            MODE_EQ:  add_step_tok(make_tok(KIND_OPER, 3'd0, lx_start, lx_len));
            default: ;
        endcase
        lx_mode = MODE_IDLE;
    endfunction

    // advance the lexer model by one character or end marker; queue its tokens
    function automatic void lex_step(input logic cmd, input logic [7:0] c);
        bit          done;
        logic [15:0] off;
        done = 1'b0;
        off  = lx_offset;
        step_tokens.delete();
        if (cmd) begin
            close_token();
            clear_lexer();
        end else begin
            case (lx_mode)
                MODE_STR: begin
                    lx_len = bump(lx_len);
                    if (c == (lx_single ? 8'h27 : 8'h22)) close_token();
                    done = 1'b1;
                end
                MODE_WORD: begin
                    if (ch_alpha(c) || ch_digit(c) || c == "_") begin
                        lx_cands = narrow_cands(lx_cands, lx_len, c);
                        lx_len   = bump(lx_len);
                        done     = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                MODE_NUM: begin
                    if (ch_digit(c)) begin
                        lx_len = bump(lx_len);
                        done   = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                MODE_EQ: begin
                    if (c == "=") begin
                        lx_len = 16'd2;
                        done   = 1'b1;
                    end
                    close_token();
                end
                default: lx_mode = MODE_IDLE;
            endcase
            if (!done && !ch_blank(c)) begin
                if (ch_alpha(c) || c == "_") begin
                    lx_mode  = MODE_WORD;
                    lx_start = off;
                    lx_len   = 16'd1;
                    lx_cands = narrow_cands(ALL_CANDIDATES, 16'd0, c);
                end else if (ch_digit(c)) begin
                    lx_mode  = MODE_NUM;
                    lx_start = off;
                    lx_len   = 16'd1;
                end else if (c == 8'h22 || c == 8'h27) begin
                    lx_mode   = MODE_STR;
                    lx_single = (c == 8'h27);
                    lx_start  = off;
                    lx_len    = 16'd1;
                end else if (c == "=") begin
                    lx_mode  = MODE_EQ;
                    lx_start = off;
                    lx_len   = 16'd1;
                end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
                    add_step_tok(make_tok(KIND_OPER, 3'd0, off, 16'd1));
                end
            end
            lx_offset = off + 16'd1;
        end
        step_count = step_tokens.size();
        if (step_count > 0) step_tokens[step_count - 1].last = 1'b1;
        foreach (step_tokens[i]) want_tokens.insert(want_tokens.size(), step_tokens[i]);
    endfunction

    function automatic void add_row(input logic cmd, input logic [7:0] ch, input bit typed = 1'b0,
                                    input kind_t kind = KIND_IDENT, input logic [2:0] idx = 3'd0,
                                    input logic [15:0] st = 16'd0, input logic [15:0] ln = 16'd0);
        stim_row_t r;
        r.cmd      = cmd;
        r.ch       = ch;
        r.typed    = typed;
        r.tok      = make_tok(kind, idx, st, ln);
        r.tok.last = 1'b1;
        stim_table.insert(stim_table.size(), r);
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] ch);
        int gap;
        if ($urandom_range(0, 63) == 0) feed_burst = !feed_burst;
        gap = feed_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        lex_step(cmd, ch);
        sent_items++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_item(1'b0, txt[i]);
    endtask

    task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            err_count++;
        end
    endtask

    initial begin : feed
        int     pick;
        int     len;
        string  w;
        logic [7:0] q;
        logic [7:0] ch;
        clear_lexer();

        // directed rows: keyword, operators, "==", adjacent tokens, strings, flush, drops
        add_row(1'b0, "i");
        add_row(1'b0, "f");
        add_row(1'b0, 8'h20, 1'b1, KIND_KEYWORD, 3'd0, 16'd0, 16'd2);
        add_row(1'b0, "+", 1'b1, KIND_OPER, 3'd0, 16'd3, 16'd1);
        add_row(1'b0, "=");
        add_row(1'b0, "=", 1'b1, KIND_OPER, 3'd0, 16'd4, 16'd2);
        add_row(1'b0, "=");
        add_row(1'b0, "_");
        add_row(1'b0, "9");
        add_row(1'b0, 8'h22);
        add_row(1'b0, 8'hFF);
        add_row(1'b0, 8'h00);
        add_row(1'b0, 8'h27);
        add_row(1'b0, 8'h22, 1'b1, KIND_STRING, 3'd0, 16'd9, 16'd5);
        add_row(1'b0, 8'h09);
        add_row(1'b0, 8'h27);
        add_row(1'b1, 8'hFF, 1'b1, KIND_STRING, 3'd0, 16'd15, 16'd1);
        add_row(1'b0, "0");
        add_row(1'b0, "7");
        add_row(1'b0, 8'h80, 1'b1, KIND_NUMBER, 3'd0, 16'd0, 16'd2);
        for (int i = 0; i < kw_words[4].len(); i++) add_row(1'b0, kw_words[4][i]);
        add_row(1'b0, "/");
        add_row(1'b0, "-", 1'b1, KIND_OPER, 3'd0, 16'd10, 16'd1);
        add_row(1'b0, "=");
        add_row(1'b1, 8'h00, 1'b1, KIND_OPER, 3'd0, 16'd11, 16'd1);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            send_item(stim_table[i].cmd, stim_table[i].ch);
            if (stim_table[i].typed) begin
                repeat (step_count) void'(want_tokens.pop_back());
                want_tokens.insert(want_tokens.size(), stim_table[i].tok);
            end
        end

        // long string and long word
        send_item(1'b0, 8'h22);
        repeat (LONG_RUN) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == 8'h22) ch = "A";
            send_item(1'b0, ch);
        end
        send_item(1'b0, 8'h22);
        send_item(1'b0, "i");
        repeat (LONG_RUN) send_item(1'b0, word_chars[$urandom_range(0, 62)]);
        send_item(1'b0, 8'h20);

        len = sent_items;
        while (sent_items < len + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_text(kw_words[$urandom_range(0, NUM_KW - 1)]);
            end else if (pick < 27) begin
                w = kw_words[$urandom_range(0, NUM_KW - 1)];
                send_text(w.substr(0, $urandom_range(0, w.len() - 1)));
                if ($urandom_range(0, 1)) send_item(1'b0, word_chars[$urandom_range(0, 62)]);
            end else if (pick < 40) begin
                send_item(1'b0, word_chars[$urandom_range(0, 52)]);
                repeat ($urandom_range(0, 7)) send_item(1'b0, word_chars[$urandom_range(0, 62)]);
            end else if (pick < 52) begin
                repeat ($urandom_range(1, 6)) send_item(1'b0, word_chars[$urandom_range(53, 62)]);
            end else if (pick < 64) begin
                q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                send_item(1'b0, q);
                repeat ($urandom_range(0, 6)) send_item(1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 85) send_item(1'b0, q);
            end else if (pick < 80) begin
                case ($urandom_range(0, 5))
                    0: send_text("+");
                    1: send_text("-");
                    2: send_text("*");
                    3: send_text("/");
                    4: send_text("=");
                    default: send_text("==");
                endcase
            end else if (pick < 93) begin
                send_item(1'b0, 8'($urandom_range(0, 255)));
            end else begin
                send_item(1'b1, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 55) begin
                send_item(1'b0, ($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13)));
            end
        end
        s_tvalid <= 1'b0;

        while (want_tokens.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : drain
        int     stall;
        token_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0) drain_burst = !drain_burst;
            stall = drain_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (want_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
                         $time, m_tuser, m_tdata[18:3], m_tdata[34:19]);
                err_count++;
            end else begin
                want = want_tokens.pop_front();
                check_field("token_kind", 16'(want.kind), 16'(m_tuser));
                check_field("keyword_index", 16'(want.kw_index), 16'(m_tdata[2:0]));
                check_field("token_start", want.start, m_tdata[18:3]);
                check_field("token_length", want.length, m_tdata[34:19]);
                check_field("last_result", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

FILE: keyword_aware_lexer.f
design/kwal_pkg.sv
design/kwal_scan.sv
design/kwal_result_queue.sv
design/keyword_aware_lexer.sv
tb/tb_top.sv
